>>> hdl/ircc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ircc_pkg
// Shared types and constants of the in-order retire cycle charger.
// ----------------------------------------------------------------------------
package ircc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALL    = 2'd3;

  // Register widths and reset values
  localparam int LAT_LOW_W  = 64;
  localparam int LAT_HIGH_W = 16;
  localparam int OVERLAP_W  = 10;
  localparam int STALL_W    = 8;
  localparam logic [LAT_LOW_W-1:0]  LAT_LOW_RESET  = 64'h0104_1403_0101_0101;
  localparam logic [LAT_HIGH_W-1:0] LAT_HIGH_RESET = 16'h0401;

  // Latency fields packed into each table register
  localparam int NUM_LOW_FIELDS  = 8;
  localparam int NUM_HIGH_FIELDS = 2;

  // Micro-op classes
  localparam int CLASS_W = 4;
  localparam logic [CLASS_W-1:0] CLS_ALU    = 4'd0;
  localparam logic [CLASS_W-1:0] CLS_BRANCH = 4'd1;
  localparam logic [CLASS_W-1:0] CLS_LOAD   = 4'd2;
  localparam logic [CLASS_W-1:0] CLS_STORE  = 4'd3;
  localparam logic [CLASS_W-1:0] CLS_MUL    = 4'd4;
  localparam logic [CLASS_W-1:0] CLS_DIV    = 4'd5;
  localparam logic [CLASS_W-1:0] CLS_FPU    = 4'd6;
  localparam logic [CLASS_W-1:0] CLS_SYSTEM = 4'd7;
  localparam logic [CLASS_W-1:0] CLS_FENCE  = 4'd8;
  localparam logic [CLASS_W-1:0] CLS_ATOMIC = 4'd9;

  // Permille arithmetic
  localparam logic [OVERLAP_W-1:0] PERMILLE    = 10'd1000;
  localparam logic [OVERLAP_W-1:0] OVERLAP_CAP = 10'd999;

  // Result widths
  localparam int CHARGE_W = 9;
  localparam int COUNT_W  = 64;
  localparam logic [CHARGE_W-1:0] CHARGE_MAX = 9'd511;

  // How the back end charges an item
  typedef struct packed {
    logic mem;     // load, store or atomic: base plus load-use stall
    logic scaled;  // non-memory with overlap credit: permille accumulation
  } ircc_kind_t;

endpackage

>>> hdl/ircc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ircc_front
// Accepts retire items, looks up the base latency and classifies the charge.
// ----------------------------------------------------------------------------
module ircc_front #(
  parameter int LATENCY_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_uop_present,
  input  logic [ircc_pkg::CLASS_W-1:0]         in_uop_class,
  input  logic [ircc_pkg::LAT_LOW_W-1:0]       lat_low,
  input  logic [ircc_pkg::LAT_HIGH_W-1:0]      lat_high,
  input  logic [ircc_pkg::OVERLAP_W-1:0]       overlap,
  output logic                                 o_valid,
  input  logic                                 o_ready,
  output logic [LATENCY_BITS-1:0]              o_base,
  output ircc_pkg::ircc_kind_t                 o_kind
);

  localparam int LB = LATENCY_BITS;

  logic [LB-1:0]        low_field  [ircc_pkg::NUM_LOW_FIELDS];
  logic [LB-1:0]        high_field [ircc_pkg::NUM_HIGH_FIELDS];
  logic [LB-1:0]        base;
  logic                 mem_cls;
  ircc_pkg::ircc_kind_t kind;
  logic                 advance;

  logic                 f_valid_r;
  logic [LB-1:0]        f_base_r;
  ircc_pkg::ircc_kind_t f_kind_r;

  // Unpack latency fields; a field that does not fit its register reads as 0
  for (genvar i = 0; i < ircc_pkg::NUM_LOW_FIELDS; i++) begin : g_low
    if ((i + 1) * LB <= ircc_pkg::LAT_LOW_W) begin : g_fit
      assign low_field[i] = lat_low[i*LB +: LB];
    end else begin : g_out
      assign low_field[i] = '0;
    end
  end

  for (genvar i = 0; i < ircc_pkg::NUM_HIGH_FIELDS; i++) begin : g_high
    if ((i + 1) * LB <= ircc_pkg::LAT_HIGH_W) begin : g_fit
      assign high_field[i] = lat_high[i*LB +: LB];
    end else begin : g_out
      assign high_field[i] = '0;
    end
  end

  // Memory-class decode
  always_comb begin
    unique case (in_uop_class) inside
      ircc_pkg::CLS_LOAD, ircc_pkg::CLS_STORE, ircc_pkg::CLS_ATOMIC: mem_cls = 1'b1;
      default: mem_cls = 1'b0;
    endcase
  end

  // Base latency lookup: absent uop and unknown classes cost one
  always_comb begin
    if (!in_uop_present) begin
      base = LB'(1);
    end else if (!in_uop_class[ircc_pkg::CLASS_W-1]) begin
      base = low_field[in_uop_class[2:0]];
    end else if (in_uop_class == ircc_pkg::CLS_FENCE) begin
      base = high_field[0];
    end else if (in_uop_class == ircc_pkg::CLS_ATOMIC) begin
      base = high_field[1];
    end else begin
      base = LB'(1);
    end
  end

  assign kind.mem    = in_uop_present & mem_cls;
  assign kind.scaled = !(in_uop_present & mem_cls) && (overlap != '0);

  // Front register
  assign advance  = !f_valid_r || o_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (advance) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      f_base_r <= base;
      f_kind_r <= kind;
    end
  end

  assign o_valid = f_valid_r;
  assign o_base  = f_base_r;
  assign o_kind  = f_kind_r;

endmodule

>>> hdl/ircc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ircc_queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module ircc_queue #(
  parameter int WIDTH = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;
  localparam int CNT_W = 2;

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign in_ready  = (count_r != CNT_W'(DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

>>> hdl/ircc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ircc_back
// Scales the base by the overlap credit, divides by 1000 through a reciprocal,
// runs the permille remainder and keeps the running totals.
// ----------------------------------------------------------------------------
module ircc_back #(
  parameter int LATENCY_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [LATENCY_BITS-1:0]            in_base,
  input  ircc_pkg::ircc_kind_t               in_kind,
  input  logic [ircc_pkg::OVERLAP_W-1:0]     overlap,
  input  logic [ircc_pkg::STALL_W-1:0]       stall,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ircc_pkg::CHARGE_W-1:0]      out_charged_cycles,
  output logic [ircc_pkg::COUNT_W-1:0]       out_charge_count,
  output logic [ircc_pkg::COUNT_W-1:0]       out_cycle_total
);

  localparam int LB    = LATENCY_BITS;
  localparam int OW    = ircc_pkg::OVERLAP_W;
  localparam int PW    = LB + OW;            // scaled product
  localparam int QW    = LB + 1;             // quotient
  localparam int SHIFT = PW;
  localparam int WW    = PW + QW;            // reciprocal product
  localparam int RW    = OW + 1;             // remainder before correction
  localparam int CW    = ((LB > ircc_pkg::STALL_W) ? LB : ircc_pkg::STALL_W) + 2;
  localparam logic [QW-1:0] RECIP = QW'((64'd1 << SHIFT) / 64'd1000);

  logic                 en;
  logic [OW-1:0]        ov_clamp;
  logic [OW-1:0]        credit;
  logic [PW-1:0]        prod;
  logic [WW-1:0]        wide;
  logic [PW-1:0]        q_times;
  logic [RW-1:0]        r_raw;
  logic [QW-1:0]        q_fix;
  logic [OW-1:0]        r_fix;
  logic [RW-1:0]        rem_sum;
  logic                 carry;
  logic [CW-1:0]        charge_raw;
  logic [ircc_pkg::CHARGE_W-1:0] charge;

  // Stage registers
  logic                 v1_r, v2_r, v3_r;
  logic [LB-1:0]        base1_r, base2_r, base3_r;
  ircc_pkg::ircc_kind_t kind1_r, kind2_r, kind3_r;
  logic [PW-1:0]        p1_r, p2_r;
  logic [QW-1:0]        q0_r, q3_r;
  logic [OW-1:0]        r3_r;

  // State and result registers
  logic                 out_valid_r;
  logic [ircc_pkg::CHARGE_W-1:0] charge_r;
  logic [ircc_pkg::COUNT_W-1:0]  count_r;
  logic [ircc_pkg::COUNT_W-1:0]  total_r;
  logic [OW-1:0]                 rem_r;

  // Whole pipeline holds while a result waits
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: base * (1000 - overlap)
  assign ov_clamp = (overlap >= ircc_pkg::PERMILLE) ? ircc_pkg::OVERLAP_CAP : overlap;
  assign credit   = ircc_pkg::PERMILLE - ov_clamp;
  assign prod     = PW'(in_base) * PW'(credit);

  // Stage 2: quotient estimate through the reciprocal, low by at most one
  assign wide = WW'(p1_r) * WW'(RECIP);

  // Stage 3: remainder and one correction step
  assign q_times = PW'(q0_r) * PW'(ircc_pkg::PERMILLE);
  assign r_raw   = RW'(p2_r - q_times);

  always_comb begin
    if (r_raw >= RW'(ircc_pkg::PERMILLE)) begin
      q_fix = q0_r + 1'b1;
      r_fix = OW'(r_raw - RW'(ircc_pkg::PERMILLE));
    end else begin
      q_fix = q0_r;
      r_fix = OW'(r_raw);
    end
  end

  // Stage 4: remainder accumulation and charge selection
  assign rem_sum = RW'(rem_r) + RW'(r3_r);
  assign carry   = (rem_sum >= RW'(ircc_pkg::PERMILLE));

  always_comb begin
    if (kind3_r.mem) begin
      charge_raw = CW'(base3_r) + CW'(stall);
    end else if (kind3_r.scaled) begin
      charge_raw = CW'(q3_r) + CW'(carry);
    end else begin
      charge_raw = CW'(base3_r);
    end
    if (charge_raw > CW'(ircc_pkg::CHARGE_MAX)) begin
      charge = ircc_pkg::CHARGE_MAX;
    end else begin
      charge = charge_raw[ircc_pkg::CHARGE_W-1:0];
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      base1_r <= in_base;
      kind1_r <= in_kind;
      p1_r    <= prod;
      base2_r <= base1_r;
      kind2_r <= kind1_r;
      p2_r    <= p1_r;
      q0_r    <= wide[SHIFT +: QW];
      base3_r <= base2_r;
      kind3_r <= kind2_r;
      q3_r    <= q_fix;
      r3_r    <= r_fix;
    end
  end

  // Result register, remainder and running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      total_r     <= '0;
      rem_r       <= '0;
    end else if (en) begin
      out_valid_r <= v3_r;
      if (v3_r) begin
        count_r <= count_r + 1'b1;
        total_r <= total_r + ircc_pkg::COUNT_W'(charge);
        if (kind3_r.scaled) begin
          rem_r <= carry ? OW'(rem_sum - RW'(ircc_pkg::PERMILLE)) : OW'(rem_sum);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && v3_r) begin
      charge_r <= charge;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_charged_cycles = charge_r;
  assign out_charge_count   = count_r;
  assign out_cycle_total    = total_r;

`ifndef ASSERT_OFF
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < ircc_pkg::PERMILLE)
    else $error("permille remainder out of range");

  a_corrected_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (r3_r < ircc_pkg::PERMILLE))
    else $error("corrected remainder out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v3_r) |=> (count_r == $past(count_r) + 1'b1))
    else $error("charge count did not advance on a result");

  a_rem_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v3_r && !kind3_r.scaled) |=> $stable(rem_r))
    else $error("remainder changed on an unscaled charge");
`endif

endmodule

>>> hdl/inorder_retire_cycle_charger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inorder_retire_cycle_charger
// Charges cycles per retiring micro-op: class latency lookup, overlap credit
// with a permille carry, load-use stall, and 64-bit running totals.
// ----------------------------------------------------------------------------
// Path: an item passes the front register, queue, multiply, reciprocal
//   multiply, correction and remainder/result stage on its way to the output.
// Throughput: one item per cycle while out_ready holds; the permille carry
//   loop is a single add-compare-subtract in the result stage.
// Reset: synchronous; registers return to their reset values, totals and the
//   remainder clear, and the pipeline and queue empty.
// ----------------------------------------------------------------------------
module inorder_retire_cycle_charger #(
  parameter int LATENCY_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ircc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ircc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_uop_present,
  input  logic [ircc_pkg::CLASS_W-1:0]        in_uop_class,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ircc_pkg::CHARGE_W-1:0]       out_charged_cycles,
  output logic [ircc_pkg::COUNT_W-1:0]        out_charge_count,
  output logic [ircc_pkg::COUNT_W-1:0]        out_cycle_total
);

  localparam int LB  = LATENCY_BITS;
  localparam int QDW = LB + $bits(ircc_pkg::ircc_kind_t);

  logic [ircc_pkg::LAT_LOW_W-1:0]  lat_low_r;
  logic [ircc_pkg::LAT_HIGH_W-1:0] lat_high_r;
  logic [ircc_pkg::OVERLAP_W-1:0]  overlap_r;
  logic [ircc_pkg::STALL_W-1:0]    stall_r;

  logic                 f_valid;
  logic                 f_ready;
  logic [LB-1:0]        f_base;
  ircc_pkg::ircc_kind_t f_kind;
  logic                 q_valid;
  logic                 q_ready;
  logic [QDW-1:0]       q_data;
  logic [LB-1:0]        q_base;
  ircc_pkg::ircc_kind_t q_kind;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_low_r  <= ircc_pkg::LAT_LOW_RESET;
      lat_high_r <= ircc_pkg::LAT_HIGH_RESET;
      overlap_r  <= '0;
      stall_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ircc_pkg::REG_LAT_LOW:  lat_low_r  <= cfg_data;
        ircc_pkg::REG_LAT_HIGH: lat_high_r <= cfg_data[ircc_pkg::LAT_HIGH_W-1:0];
        ircc_pkg::REG_OVERLAP:  overlap_r  <= cfg_data[ircc_pkg::OVERLAP_W-1:0];
        ircc_pkg::REG_STALL:    stall_r    <= cfg_data[ircc_pkg::STALL_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: lookup and classification
  ircc_front #(
    .LATENCY_BITS (LB)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_uop_present (in_uop_present),
    .in_uop_class   (in_uop_class),
    .lat_low        (lat_low_r),
    .lat_high       (lat_high_r),
    .overlap        (overlap_r),
    .o_valid        (f_valid),
    .o_ready        (f_ready),
    .o_base         (f_base),
    .o_kind         (f_kind)
  );

  // Decoupling queue
  ircc_queue #(
    .WIDTH (QDW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_base, f_kind}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  assign q_base = q_data[QDW-1 -: LB];
  assign q_kind = q_data[$bits(ircc_pkg::ircc_kind_t)-1:0];

  // Back end: scaling, division by 1000, totals
  ircc_back #(
    .LATENCY_BITS (LB)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (q_valid),
    .in_ready           (q_ready),
    .in_base            (q_base),
    .in_kind            (q_kind),
    .overlap            (overlap_r),
    .stall              (stall_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_charged_cycles (out_charged_cycles),
    .out_charge_count   (out_charge_count),
    .out_cycle_total    (out_cycle_total)
  );

endmodule

>>> test/inorder_retire_cycle_charger_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inorder_retire_cycle_charger_tb
// Self-checking bench for the retire cycle charger. A directed table runs
// first: reset latencies, every uop class, saturated tables with the largest
// load-use stall, and the overlap cap. Random phases follow, each with a
// fresh register setting. A predictor in the bench tracks the permille
// carry and the 64-bit totals. Both channels get random idle bursts.
// ----------------------------------------------------------------------------
module inorder_retire_cycle_charger_tb;

  localparam int LAT_FIELD_W   = 8;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 80;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int MAX_REPORTS   = 10;
  localparam int NO_CHARGE     = -1;  // table row checked by predictor only
  localparam logic [ircc_pkg::CLASS_W-1:0] CLS_UNK_LO = 4'd10;
  localparam logic [ircc_pkg::CLASS_W-1:0] CLS_UNK_HI = 4'd15;

  typedef struct {
    logic [ircc_pkg::CHARGE_W-1:0] cycles;
    logic [ircc_pkg::COUNT_W-1:0]  count;
    logic [ircc_pkg::COUNT_W-1:0]  total;
  } charge_t;

  typedef struct {
    logic                            is_cfg;
    logic [ircc_pkg::CFG_IDX_W-1:0]  idx;
    logic [ircc_pkg::CFG_DATA_W-1:0] data;
    logic                            present;
    logic [ircc_pkg::CLASS_W-1:0]    cls;
    int                              charge;
  } stim_row_t;

  // DUT ports
  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ircc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ircc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic                            in_uop_present;
  logic [ircc_pkg::CLASS_W-1:0]    in_uop_class;
  logic                            out_valid;
  logic                            out_ready;
  logic [ircc_pkg::CHARGE_W-1:0]   out_charged_cycles;
  logic [ircc_pkg::COUNT_W-1:0]    out_charge_count;
  logic [ircc_pkg::COUNT_W-1:0]    out_cycle_total;

  // Shadow registers and state of the charger
  logic [ircc_pkg::LAT_LOW_W-1:0]  lat_low_q;
  logic [ircc_pkg::LAT_HIGH_W-1:0] lat_high_q;
  logic [ircc_pkg::OVERLAP_W-1:0]  overlap_q;
  logic [ircc_pkg::STALL_W-1:0]    stall_q;
  int unsigned                     permille_carry;
  logic [ircc_pkg::COUNT_W-1:0]    charges_seen;
  logic [ircc_pkg::COUNT_W-1:0]    cycles_summed;

  charge_t   pending_charges[$];
  stim_row_t directed_rows[$];

  int  error_count;
  int  items_sent;
  int  charges_checked;
  int  cfg_writes;
  int  cycle_count = 0;
  bit  tail_quiet;

  inorder_retire_cycle_charger u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_uop_present     (in_uop_present),
    .in_uop_class       (in_uop_class),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_charged_cycles (out_charged_cycles),
    .out_charge_count   (out_charge_count),
    .out_cycle_total    (out_cycle_total)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d charges pending", cycle_count,
               pending_charges.size());
      $display("** inorder_retire_cycle_charger: FAILED **");
      $finish;
    end
  end

  // Result-side backpressure: random stall bursts, none in the tail
  initial begin
    out_ready = 1'b0;
    forever begin
      if (!tail_quiet && $urandom_range(0, 2) == 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  end

  // Charge predictor: lookup, permille carry, stall, running totals
  task automatic predict_charge(input logic present,
                                input logic [ircc_pkg::CLASS_W-1:0] cls,
                                output charge_t res);
    int unsigned base;
    int unsigned ov;
    int unsigned acc;
    int unsigned cyc;
    logic        is_mem;
    if (!present)
      base = 1;
    else if (cls <= ircc_pkg::CLS_SYSTEM)
      base = 32'(lat_low_q[cls*LAT_FIELD_W +: LAT_FIELD_W]);
    else if (cls <= ircc_pkg::CLS_ATOMIC)
      base = 32'(lat_high_q[(cls-ircc_pkg::CLS_FENCE)*LAT_FIELD_W +: LAT_FIELD_W]);
    else
      base = 1;
    is_mem = present && (cls == ircc_pkg::CLS_LOAD || cls == ircc_pkg::CLS_STORE ||
                         cls == ircc_pkg::CLS_ATOMIC);
    ov = (overlap_q >= ircc_pkg::PERMILLE) ? 32'(ircc_pkg::OVERLAP_CAP) : 32'(overlap_q);
    if (!is_mem && ov != 0) begin
      acc = permille_carry + base * (32'(ircc_pkg::PERMILLE) - ov);
      cyc = acc / 32'(ircc_pkg::PERMILLE);
      permille_carry = acc % 32'(ircc_pkg::PERMILLE);
    end else begin
      cyc = base;
    end
    if (is_mem)
      cyc = cyc + 32'(stall_q);
    if (cyc > 32'(ircc_pkg::CHARGE_MAX))
      cyc = 32'(ircc_pkg::CHARGE_MAX);
    charges_seen  = charges_seen + 64'd1;
    cycles_summed = cycles_summed + 64'(cyc);
    res.cycles = cyc[ircc_pkg::CHARGE_W-1:0];
    res.count  = charges_seen;
    res.total  = cycles_summed;
  endtask

  // Result checker
  always @(posedge clk) begin
    charge_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (pending_charges.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result: cycles %0d count %0d total %0d", $realtime,
                   out_charged_cycles, out_charge_count, out_cycle_total);
      end else begin
        exp_c = pending_charges.pop_front();
        charges_checked = charges_checked + 1;
        if (out_charged_cycles !== exp_c.cycles || out_charge_count !== exp_c.count ||
            out_cycle_total !== exp_c.total) begin
          error_count = error_count + 1;
          if (error_count <= MAX_REPORTS)
            $display("%0t: mismatch: cycles %0d/%0d count %0d/%0d total %0d/%0d (exp/got)",
                     $realtime, exp_c.cycles, out_charged_cycles, exp_c.count,
                     out_charge_count, exp_c.total, out_cycle_total);
        end
      end
    end
  end

  // One input transfer, with an optional idle burst ahead of it
  task automatic send_uop(input logic present, input logic [ircc_pkg::CLASS_W-1:0] cls,
                          input int charge, input bit gaps);
    charge_t res;
    int      gap_n;
    gap_n = (gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap_n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap_n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_uop_present <= present;
    in_uop_class   <= cls;
    do @(posedge clk); while (!in_ready);
    predict_charge(present, cls, res);
    if (charge != NO_CHARGE)
      res.cycles = charge[ircc_pkg::CHARGE_W-1:0];
    pending_charges.push_back(res);
    items_sent = items_sent + 1;
  endtask

  // Stop sending and wait until every expected charge has come out
  task automatic drain_charges();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_charges.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ircc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ircc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ircc_pkg::REG_LAT_LOW:  lat_low_q  = data;
      ircc_pkg::REG_LAT_HIGH: lat_high_q = data[ircc_pkg::LAT_HIGH_W-1:0];
      ircc_pkg::REG_OVERLAP:  overlap_q  = data[ircc_pkg::OVERLAP_W-1:0];
      ircc_pkg::REG_STALL:    stall_q    = data[ircc_pkg::STALL_W-1:0];
      default: ;
    endcase
    cfg_writes = cfg_writes + 1;
  endtask

  function automatic stim_row_t uop_row(input logic present,
                                        input logic [ircc_pkg::CLASS_W-1:0] cls,
                                        input int charge);
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.idx     = '0;
    r.data    = '0;
    r.present = present;
    r.cls     = cls;
    r.charge  = charge;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [ircc_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [ircc_pkg::CFG_DATA_W-1:0] data);
    stim_row_t r;
    r         = uop_row(1'b0, '0, NO_CHARGE);
    r.is_cfg  = 1'b1;
    r.idx     = idx;
    r.data    = data;
    return r;
  endfunction

  function automatic logic [ircc_pkg::CFG_DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Random register setting for one phase, extremes included
  task automatic program_random_setting();
    logic [ircc_pkg::CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = '1;
      default: v = rand_word();
    endcase
    write_reg(ircc_pkg::REG_LAT_LOW, v);
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = '1;
      default: v = rand_word();
    endcase
    write_reg(ircc_pkg::REG_LAT_HIGH, v);
    case ($urandom_range(0, 6))
      0: v = 0;
      1: v = 1;
      2: v = 500;
      3: v = 64'(ircc_pkg::OVERLAP_CAP);
      4: v = 64'(ircc_pkg::PERMILLE);
      5: v = {rand_word() | 64'h3FF};
      default: v = rand_word();
    endcase
    write_reg(ircc_pkg::REG_OVERLAP, v);
    case ($urandom_range(0, 2))
      0: v = 0;
      1: v = 64'hFF;
      default: v = rand_word();
    endcase
    write_reg(ircc_pkg::REG_STALL, v);
  endtask

  // Main sequence
  initial begin
    logic [ircc_pkg::CLASS_W-1:0] cls;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_uop_present = 1'b0;
    in_uop_class   = '0;
    tail_quiet     = 1'b0;
    error_count     = 0;
    items_sent      = 0;
    charges_checked = 0;
    cfg_writes      = 0;
    lat_low_q      = ircc_pkg::LAT_LOW_RESET;
    lat_high_q     = ircc_pkg::LAT_HIGH_RESET;
    overlap_q      = '0;
    stall_q        = '0;
    permille_carry = 0;
    charges_seen   = '0;
    cycles_summed  = '0;

    // Reset latencies, every class, absent and unknown uops
    directed_rows.push_back(uop_row(1'b0, CLS_UNK_HI, 1));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_ALU,    1));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_BRANCH, 1));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_LOAD,   1));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_STORE,  1));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_MUL,    3));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_DIV,    20));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_FPU,    4));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_SYSTEM, 1));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_FENCE,  1));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_ATOMIC, 4));
    directed_rows.push_back(uop_row(1'b1, CLS_UNK_LO, 1));
    directed_rows.push_back(uop_row(1'b1, CLS_UNK_HI, 1));
    // Full tables and largest stall: memory uops charge 510, just under the top charge
    directed_rows.push_back(cfg_row(ircc_pkg::REG_LAT_LOW,  '1));
    directed_rows.push_back(cfg_row(ircc_pkg::REG_LAT_HIGH, 64'hFFFF));
    directed_rows.push_back(cfg_row(ircc_pkg::REG_STALL,    64'hFF));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_LOAD,   510));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_STORE,  510));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_ATOMIC, 510));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_DIV,    255));
    directed_rows.push_back(uop_row(1'b1, CLS_UNK_HI, 1));
    // Overlap of 1000 acts as 999: carry builds up, memory is unaffected
    directed_rows.push_back(cfg_row(ircc_pkg::REG_OVERLAP, 64'(ircc_pkg::PERMILLE)));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_ALU,    NO_CHARGE));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_ALU,    NO_CHARGE));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_ALU,    NO_CHARGE));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_ALU,    NO_CHARGE));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_LOAD,   510));
    directed_rows.push_back(uop_row(1'b0, ircc_pkg::CLS_LOAD,   NO_CHARGE));
    // Top overlap code and a zero latency
    directed_rows.push_back(cfg_row(ircc_pkg::REG_OVERLAP, 64'h3FF));
    directed_rows.push_back(cfg_row(ircc_pkg::REG_LAT_LOW, '0));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_ALU,    0));
    directed_rows.push_back(uop_row(1'b1, ircc_pkg::CLS_FENCE,  NO_CHARGE));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain_charges();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_uop(directed_rows[i].present, directed_rows[i].cls, directed_rows[i].charge, 1'b1);
      end
    end

    // Random phases, each with its own register setting; the last one runs flat out
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_charges();
      program_random_setting();
      if (ph == NUM_PHASES - 1)
        tail_quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // bias toward memory classes so the stall path sees traffic
        if ($urandom_range(0, 3) == 0)
          case ($urandom_range(0, 2))
            0: cls = ircc_pkg::CLS_LOAD;
            1: cls = ircc_pkg::CLS_STORE;
            default: cls = ircc_pkg::CLS_ATOMIC;
          endcase
        else
          cls = ircc_pkg::CLASS_W'($urandom_range(0, 15));
        send_uop($urandom_range(0, 4) != 0, cls, NO_CHARGE, !tail_quiet);
      end
    end

    drain_charges();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_charges.size() != 0)
      error_count = error_count + pending_charges.size();

    $display("run covered %0d uops, %0d charges checked, %0d register writes",
             items_sent, charges_checked, cfg_writes);
    $display("%0d random phases plus directed table, %0d errors", NUM_PHASES, error_count);
    if (error_count == 0) begin
      $display("** inorder_retire_cycle_charger: PASSED **");
    end else begin
      $display("** inorder_retire_cycle_charger: FAILED **");
    end
    $finish;
  end

endmodule
